>>> rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion helpers for the range remap table RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SRRT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define SRRT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define SRRT_ASSERT(lbl, clk, rstn, prop, msg)
`define SRRT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/srrt_pkg.sv
// ============================================================================
// Range remap table package
// Action codes, the stored entry layout and the control bundle of the unit.
// ============================================================================
`default_nettype none

package srrt_pkg;

  // Action codes carried in the input item's tuser.
  localparam logic [1:0] ACT_WRITE     = 2'd0;
  localparam logic [1:0] ACT_TRANSLATE = 2'd1;
  localparam logic [1:0] ACT_CLEAR     = 2'd2;

  localparam int VALUE_W = 32;

  // One stored range entry, as held in the entry memory.
  typedef struct packed {
    logic [VALUE_W-1:0] length;
    logic [VALUE_W-1:0] source;
    logic [VALUE_W-1:0] dest;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Control from the sequencer to the shared compare and remap unit.
  typedef struct packed {
    logic load;    // take a new value, forget any pick
    logic eval;    // entry read data is valid this cycle
    logic finish;  // apply the pick of the finished stage
  } unit_ctl_t;

endpackage

`default_nettype wire

>>> rtl/staged_range_remap_table_unit.sv
// ============================================================================
// Staged range remap table
// Chain of range remapping stages scanned one entry per cycle.
// ============================================================================
//
//  Channel   Dir   Handshake                    Payload
//  in_       in    in_tvalid / in_tready        tuser action, tdata entry/value
//  out_      out   out_tvalid / out_tready      tdata final and smallest value
//  cfg_      in    APB psel/penable/pready      active_stages at address 0
//
// A write or clear item is handled in the idle step. A translate item scans
// each of its n stages, n being active_stages capped at STAGES, then drains
// and finishes it, set by the single read port of the entry memory: one
// entry per cycle. After reset a clearing pass over all STAGES*ENTRIES_PER_STAGE
// entries wipes the valid bits; no item is accepted meanwhile.
// The result waits in an output register; a stalled result holds the
// sequencer in its final step but a new item is taken once it is moved on.
`default_nettype none

`include "assert_macros.svh"

module staged_range_remap_table_unit #(
  parameter int STAGES            = 8,
  parameter int ENTRIES_PER_STAGE = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input channel.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tuser: action[1:0]
  input  wire logic [1:0]   in_tuser,
  // tdata: stage_select[2:0], entry_slot[7:3], dest_start[39:8],
  //        source_start[71:40], range_length[103:72], value_in[135:104]
  input  wire logic [135:0] in_tdata,
  // Result channel.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: final_value[31:0], smallest_value[63:32]
  output logic [63:0]       out_tdata,
  // Configuration port.
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int DEPTH = STAGES * ENTRIES_PER_STAGE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
  localparam int CW    = $clog2(STAGES + 1);
  localparam int VW    = srrt_pkg::VALUE_W;

  // Register index decoded from paddr[2].
  localparam logic REG_ACTIVE_STAGES = 1'b0;

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [LW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] stage_r, stage_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          eval_r;
  logic [3:0]    active_r;
  logic [VW-1:0] min_r, min_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] out_final_r, out_min_r;
  logic          out_load;

  logic [1:0]    act;
  logic [2:0]    stage_sel;
  logic [4:0]    slot_sel;
  logic [VW-1:0] in_dest, in_source, in_length, in_value;
  logic          in_fire;
  logic          wr_ok;
  logic [31:0]   wr_idx;
  logic [CW-1:0] n_sat;

  logic          vram_we;
  logic [AW-1:0] vram_waddr;
  logic          vram_wdata;
  logic          vram_rdata;
  srrt_pkg::entry_t dram_wdata, dram_rdata;

  srrt_pkg::unit_ctl_t ctl;
  logic [VW-1:0] unit_value;
  logic [VW-1:0] new_min;

  // Unpack the input item.
  assign act       = in_tuser;
  assign stage_sel = in_tdata[2:0];
  assign slot_sel  = in_tdata[7:3];
  assign in_dest   = in_tdata[39:8];
  assign in_source = in_tdata[71:40];
  assign in_length = in_tdata[103:72];
  assign in_value  = in_tdata[135:104];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Entry writes outside the table are dropped.
  assign wr_ok  = in_fire && (act == srrt_pkg::ACT_WRITE)
               && (32'(stage_sel) < 32'(STAGES))
               && (32'(slot_sel) < 32'(ENTRIES_PER_STAGE));
  assign wr_idx = 32'(stage_sel) * 32'(ENTRIES_PER_STAGE) + 32'(slot_sel);

  // Stage count capped at the number of stages built.
  assign n_sat = (32'(active_r) > 32'(STAGES)) ? CW'(STAGES) : CW'(active_r);

  // Valid bit memory: cleared by the pass after reset, set by entry writes.
  assign vram_we    = wr_ok || (state_r == ST_CLEAR);
  assign vram_waddr = (state_r == ST_CLEAR) ? addr_r : AW'(wr_idx);
  assign vram_wdata = (state_r != ST_CLEAR);

  srrt_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_valid_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (addr_r),
    .rdata (vram_rdata)
  );

  // Entry memory holding length, source start and destination start.
  assign dram_wdata = '{length: in_length, source: in_source, dest: in_dest};

  srrt_ram #(
    .WIDTH (srrt_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (AW'(wr_idx)),
    .wdata (dram_wdata),
    .raddr (addr_r),
    .rdata (dram_rdata)
  );

  // Shared compare and remap unit.
  assign ctl.load   = in_fire && (act == srrt_pkg::ACT_TRANSLATE);
  assign ctl.eval   = eval_r;
  assign ctl.finish = (state_r == ST_FIN);

  srrt_remap_unit u_remap (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .value_in  (in_value),
    .ent       (dram_rdata),
    .ent_valid (vram_rdata),
    .value_out (unit_value)
  );

  // Running minimum including the value being delivered.
  assign new_min  = (unit_value < min_r) ? unit_value : min_r;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    slot_nxt  = slot_r;
    stage_nxt = stage_r;
    n_nxt     = n_r;
    min_nxt   = min_r;
    case (state_r)
      ST_CLEAR: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(DEPTH - 1)) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (act)
            srrt_pkg::ACT_TRANSLATE: begin
              n_nxt     = n_sat;
              stage_nxt = '0;
              slot_nxt  = '0;
              addr_nxt  = '0;
              state_nxt = (n_sat == '0) ? ST_DONE : ST_SCAN;
            end
            srrt_pkg::ACT_CLEAR: begin
              min_nxt = '1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + 1'b1;
        slot_nxt = slot_r + 1'b1;
        if (slot_r == LW'(ENTRIES_PER_STAGE - 1)) begin
          slot_nxt  = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        stage_nxt = stage_r + 1'b1;
        state_nxt = (CW'(stage_r + 1'b1) == n_r) ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        if (out_load) begin
          min_nxt   = new_min;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      slot_r      <= '0;
      stage_r     <= '0;
      n_r         <= '0;
      eval_r      <= 1'b0;
      min_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      slot_r      <= slot_nxt;
      stage_r     <= stage_nxt;
      n_r         <= n_nxt;
      eval_r      <= (state_r == ST_SCAN);
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_final_r <= unit_value;
      out_min_r   <= new_min;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_min_r, out_final_r};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 4'd7;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == REG_ACTIVE_STAGES)) begin
      active_r <= cfg_pwdata[3:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ACTIVE_STAGES) ? {28'd0, active_r} : 32'd0;

  // A result only comes up from the final step of a translate.
  `SRRT_ASSERT(a_rise_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r) == ST_DONE, "result raised outside done step")
  // The delivered minimum never exceeds the delivered value.
  `SRRT_ASSERT(a_min_le_final, clk, rst_n, out_valid_r |-> (out_min_r <= out_final_r), "minimum above final value")
  // The drain step always follows the last slot read.
  `SRRT_ASSERT(a_drain_after_scan, clk, rst_n, (state_r == ST_DRAIN) |-> ($past(state_r) == ST_SCAN), "drain not after scan")
  // The stage counter stays below the stage count while a stage is worked on.
  `SRRT_NEVER(a_stage_range, clk, rst_n, ((state_r == ST_SCAN) || (state_r == ST_FIN)) && (stage_r >= n_r), "stage counter out of range")

endmodule

`default_nettype wire

>>> rtl/srrt_ram.sv
// ============================================================================
// Generic RAM
// Single write port, single read port with registered read data.
// ============================================================================
`default_nettype none

module srrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/srrt_remap_unit.sv
// ============================================================================
// Shared compare and remap unit
// Tracks the best entry of the stage being scanned and applies it at the end.
// ============================================================================
`default_nettype none

module srrt_remap_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire srrt_pkg::unit_ctl_t            ctl,
  input  wire logic [srrt_pkg::VALUE_W-1:0]   value_in,
  input  wire srrt_pkg::entry_t               ent,
  input  wire logic                           ent_valid,
  output logic      [srrt_pkg::VALUE_W-1:0]   value_out
);

  logic [srrt_pkg::VALUE_W-1:0] v_r, v_nxt;
  logic                         found_r, found_nxt;
  srrt_pkg::entry_t             best_r, best_nxt;
  logic                         hit;
  logic [srrt_pkg::VALUE_W:0]   end_sum;
  logic                         covered;

  // Candidate test: valid, starts at or below the value, and beats the pick.
  // A strict compare keeps the lowest slot among equal source starts.
  assign hit = ent_valid && (ent.source <= v_r) && (!found_r || (ent.source > best_r.source));

  // End of range is checked at 33 bits so a range reaching the top never wraps.
  assign end_sum = {1'b0, best_r.source} + {1'b0, best_r.length};
  assign covered = found_r && ({1'b0, v_r} < end_sum);

  always_comb begin
    v_nxt     = v_r;
    found_nxt = found_r;
    best_nxt  = best_r;
    if (ctl.load) begin
      v_nxt     = value_in;
      found_nxt = 1'b0;
    end else if (ctl.eval) begin
      if (hit) begin
        found_nxt = 1'b1;
        best_nxt  = ent;
      end
    end else if (ctl.finish) begin
      if (covered) begin
        v_nxt = v_r - best_r.source + best_r.dest;
      end
      found_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    v_r    <= v_nxt;
    best_r <= best_nxt;
  end

  assign value_out = v_r;

endmodule

`default_nettype wire
